### rtl/core/glmf_pkg.sv
// ----------------------------------------------------------------------------
// glmf_pkg
// shared types and constants of the grid local maximum finder
// ----------------------------------------------------------------------------
package glmf_pkg;

    localparam int ROW_BITS       = 12;
    localparam int COL_BITS       = 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 12;

    localparam logic [ROW_BITS-1:0] ROWS_AT_RESET = 12'd3;
    localparam logic [COL_BITS-1:0] COLS_AT_RESET = 8'd3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ROW_COUNT    = 2'd0,
        CFG_COLUMN_COUNT = 2'd1
    } t_cfg_index;

    typedef struct packed {
        logic shift;
        logic load_tail;
    } t_cell_ctrl;

endpackage

### rtl/core/glmf_cell.sv
// ----------------------------------------------------------------------------
// glmf_cell
// one sample cell of a line chain, loads the tail sample or its neighbor
// ----------------------------------------------------------------------------
module glmf_cell
    import glmf_pkg::*;
#(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  t_cell_ctrl       i_ctrl,
    input  logic [WIDTH-1:0] i_tail,
    input  logic [WIDTH-1:0] i_next,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_q;
    logic [WIDTH-1:0] n_q;

    assign n_q = i_ctrl.load_tail ? i_tail : i_next;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

### rtl/core/glmf_line.sv
// ----------------------------------------------------------------------------
// glmf_line
// line delay built as a chain of cells, delay set by the column count
// ----------------------------------------------------------------------------
module glmf_line
    import glmf_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                i_clk,
    input  logic                i_shift,
    input  logic [COL_BITS-1:0] i_len,
    input  logic [WIDTH-1:0]    i_tail,
    output logic [WIDTH-1:0]    o_head,
    output logic [WIDTH-1:0]    o_second
);

    logic [WIDTH-1:0] w_q [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_cell_ctrl       w_ctrl;
        logic [WIDTH-1:0] w_next;

        assign w_ctrl.shift     = i_shift;
        assign w_ctrl.load_tail = (i_len == COL_BITS'(k + 1));

        if (k == DEPTH - 1) begin : g_end
            assign w_next = i_tail;
        end else begin : g_mid
            assign w_next = w_q[k+1];
        end

        glmf_cell #(
            .WIDTH(WIDTH)
        ) u_cell (
            .i_clk (i_clk),
            .i_ctrl(w_ctrl),
            .i_tail(i_tail),
            .i_next(w_next),
            .o_q   (w_q[k])
        );
    end

    assign o_head   = w_q[0];
    assign o_second = w_q[1];

endmodule

### rtl/core/grid_local_maximum_finder.sv
// ----------------------------------------------------------------------------
// grid_local_maximum_finder
// 4-neighbor local maximum detection on a row-major sample stream
// output: a result is registered on the transfer that causes it
// throughput: one sample per cycle while the input is not stalled, each line chain shifts one cell per transfer
// reset: row and column counts 3, grid position, peak flag and output valid cleared
// line contents are not reset, a grid reads only samples of its own rows
// ----------------------------------------------------------------------------
module grid_local_maximum_finder
    import glmf_pkg::*;
#(
    parameter int MAX_COLUMNS = 128,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_peak_value,
    output logic [ROW_BITS-1:0]           o_peak_row,
    output logic [COL_BITS-1:0]           o_peak_col,
    output logic                          o_none_found
);

    localparam int COLS_CAP = (MAX_COLUMNS > 255) ? 255 : MAX_COLUMNS;

    logic [ROW_BITS-1:0] r_rows;
    logic [COL_BITS-1:0] r_cols;
    logic [ROW_BITS-1:0] r_row;
    logic [COL_BITS-1:0] r_col;
    logic                r_peak_seen;
    logic                r_out_valid;

    logic signed [SAMPLE_BITS-1:0] r_left;
    logic signed [SAMPLE_BITS-1:0] r_peak_value;
    logic [ROW_BITS-1:0]           r_peak_row;
    logic [COL_BITS-1:0]           r_peak_col;
    logic                          r_none_found;

    logic [ROW_BITS-1:0] n_rows;
    logic [COL_BITS-1:0] n_cols;

    logic                          w_accept;
    logic                          w_cfg_hit;
    logic signed [SAMPLE_BITS-1:0] w_mid;
    logic signed [SAMPLE_BITS-1:0] w_right;
    logic signed [SAMPLE_BITS-1:0] w_up;
    logic [SAMPLE_BITS-1:0]        w_mid_raw;
    logic [SAMPLE_BITS-1:0]        w_right_raw;
    logic [SAMPLE_BITS-1:0]        w_up_raw;
    logic                          w_interior;
    logic                          w_peak;
    logic                          w_col_last;
    logic                          w_row_last;
    logic                          w_none;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_cfg_hit  = i_cfg_we && (i_cfg_index == CFG_ROW_COUNT ||
                                     i_cfg_index == CFG_COLUMN_COUNT);

    assign n_rows = (i_cfg_data == '0) ? ROW_BITS'(1) : i_cfg_data;

    always_comb begin
        if (i_cfg_data[COL_BITS-1:0] == '0) begin
            n_cols = COL_BITS'(1);
        end else if (i_cfg_data[COL_BITS-1:0] > COL_BITS'(COLS_CAP)) begin
            n_cols = COL_BITS'(COLS_CAP);
        end else begin
            n_cols = i_cfg_data[COL_BITS-1:0];
        end
    end

    // middle row: current sample shifted one line back
    glmf_line #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(COLS_CAP)
    ) u_line_mid (
        .i_clk   (i_clk),
        .i_shift (w_accept),
        .i_len   (r_cols),
        .i_tail  (i_sample),
        .o_head  (w_mid_raw),
        .o_second(w_right_raw)
    );

    // upper row: middle row shifted one more line back
    glmf_line #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(COLS_CAP)
    ) u_line_up (
        .i_clk   (i_clk),
        .i_shift (w_accept),
        .i_len   (r_cols),
        .i_tail  (w_mid_raw),
        .o_head  (w_up_raw),
        .o_second()
    );

    assign w_mid   = w_mid_raw;
    assign w_right = w_right_raw;
    assign w_up    = w_up_raw;

    assign w_interior = (r_row >= ROW_BITS'(2)) && (r_col != '0) &&
                        (r_col < r_cols - COL_BITS'(1));
    assign w_peak     = w_interior && (w_mid > w_up) && (w_mid > i_sample) &&
                        (w_mid > r_left) && (w_mid > w_right);
    assign w_col_last = (r_col == r_cols - COL_BITS'(1));
    assign w_row_last = (r_row == r_rows - ROW_BITS'(1));
    assign w_none     = w_col_last && w_row_last && !r_peak_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows      <= ROWS_AT_RESET;
            r_cols      <= COLS_AT_RESET;
            r_row       <= '0;
            r_col       <= '0;
            r_peak_seen <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_hit) begin
                if (i_cfg_index == CFG_ROW_COUNT) begin
                    r_rows <= n_rows;
                end else begin
                    r_cols <= n_cols;
                end
                r_row       <= '0;
                r_col       <= '0;
                r_peak_seen <= 1'b0;
            end else if (w_accept) begin
                if (w_col_last) begin
                    r_col <= '0;
                    if (w_row_last) begin
                        r_row       <= '0;
                        r_peak_seen <= 1'b0;
                    end else begin
                        r_row <= r_row + ROW_BITS'(1);
                    end
                end else begin
                    r_col <= r_col + COL_BITS'(1);
                    if (w_peak) begin
                        r_peak_seen <= 1'b1;
                    end
                end
            end

            if (w_accept && (w_peak || w_none)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_left <= w_mid;
        end
        if (w_accept && w_peak) begin
            r_peak_value <= w_mid;
            r_peak_row   <= r_row;
            r_peak_col   <= r_col + COL_BITS'(1);
            r_none_found <= 1'b0;
        end else if (w_accept && w_none) begin
            r_peak_value <= '0;
            r_peak_row   <= r_rows;
            r_peak_col   <= r_cols;
            r_none_found <= 1'b1;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_peak_value = r_peak_value;
    assign o_peak_row   = r_peak_row;
    assign o_peak_col   = r_peak_col;
    assign o_none_found = r_none_found;

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col < r_cols)
        else $error("column position beyond column count");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row < r_rows)
        else $error("row position beyond row count");

    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid)
        else $error("input stalled with empty output register");

    a_grid_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_col_last && w_row_last) |=> !r_peak_seen)
        else $error("peak flag kept across grid end");

    a_peak_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_peak) |=> (r_peak_row >= ROW_BITS'(2) &&
                                  r_peak_col >= COL_BITS'(2) && !r_none_found))
        else $error("peak reported on a border cell");

endmodule

### bench/grid_local_maximum_finder_tb.sv
// ----------------------------------------------------------------------------
// grid_local_maximum_finder_tb
// self-checking bench for the 4-neighbor grid peak finder: a short table of
// directed grids (extremes, plateau, degenerate sizes, ignored register
// indexes), then saturated and tall grids and random grids of mixed shapes
// with random content, checked against typed table rows or an in-bench peak
// predictor, mostly under random sender idles and receiver stalls
// ----------------------------------------------------------------------------
module grid_local_maximum_finder_tb
    import glmf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH   = 128;
    localparam int SAMPLE_W     = 16;
    localparam int RANDOM_ITEMS = 1950;
    localparam int SETTLE_WAIT  = 3;
    localparam int DRAIN_WAIT   = 10;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LOW  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HIGH = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic [ROW_BITS-1:0]        row;
        logic [COL_BITS-1:0]        col;
        logic                       none;
    } t_peak_report;

    typedef enum logic {STEP_SAMPLE, STEP_WRITE} t_step_kind;

    typedef struct packed {
        t_step_kind                kind;
        logic [CFG_INDEX_BITS-1:0] reg_index;
        logic [SAMPLE_W-1:0]       value;
        logic                      typed;
        t_peak_report              report;
    } t_plan_step;

    localparam t_peak_report NO_REPORT = '0;
    localparam int DIRECTED_LEN = 33;

    // typed rows carry the result read straight off the grid
    localparam t_plan_step DIRECTED_PLAN [DIRECTED_LEN] = '{
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h8000, 1'b0, NO_REPORT},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h8000, 1'b0, NO_REPORT},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h8000, 1'b0, NO_REPORT},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h8000, 1'b0, NO_REPORT},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h7FFF, 1'b0, NO_REPORT},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h8000, 1'b0, NO_REPORT},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h8000, 1'b0, NO_REPORT},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h8000, 1'b1, '{16'sh7FFF, 12'd2, 8'd2, 1'b0}},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h8000, 1'b0, NO_REPORT},
        // zero counts act as a 1x1 grid
        '{STEP_WRITE, CFG_ROW_COUNT, 16'h0000, 1'b0, NO_REPORT},
        '{STEP_WRITE, CFG_COLUMN_COUNT, 16'h0000, 1'b0, NO_REPORT},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h0001, 1'b1, '{16'sh0000, 12'd1, 8'd1, 1'b1}},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'hFFFF, 1'b1, '{16'sh0000, 12'd1, 8'd1, 1'b1}},
        // unknown indexes leave the counts alone
        '{STEP_WRITE, CFG_SPARE_LOW, 16'h0005, 1'b0, NO_REPORT},
        '{STEP_WRITE, CFG_SPARE_HIGH, 16'h0FFF, 1'b0, NO_REPORT},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h0000, 1'b1, '{16'sh0000, 12'd1, 8'd1, 1'b1}},
        // 2x2 grid has no interior cell
        '{STEP_WRITE, CFG_ROW_COUNT, 16'h0002, 1'b0, NO_REPORT},
        '{STEP_WRITE, CFG_COLUMN_COUNT, 16'h0002, 1'b0, NO_REPORT},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h0005, 1'b0, NO_REPORT},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'hFFFB, 1'b0, NO_REPORT},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h0064, 1'b0, NO_REPORT},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h0007, 1'b1, '{16'sh0000, 12'd2, 8'd2, 1'b1}},
        // flat 3x3 grid, ties are not peaks
        '{STEP_WRITE, CFG_ROW_COUNT, 16'h0003, 1'b0, NO_REPORT},
        '{STEP_WRITE, CFG_COLUMN_COUNT, 16'h0003, 1'b0, NO_REPORT},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h0000, 1'b0, NO_REPORT},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h0000, 1'b0, NO_REPORT},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h0000, 1'b0, NO_REPORT},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h0000, 1'b0, NO_REPORT},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h0000, 1'b0, NO_REPORT},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h0000, 1'b0, NO_REPORT},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h0000, 1'b0, NO_REPORT},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h0000, 1'b0, NO_REPORT},
        '{STEP_SAMPLE, CFG_ROW_COUNT, 16'h0000, 1'b1, '{16'sh0000, 12'd3, 8'd3, 1'b1}}
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]      i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic signed [SAMPLE_W-1:0]    i_sample = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]    o_peak_value;
    logic [ROW_BITS-1:0]           o_peak_row;
    logic [COL_BITS-1:0]           o_peak_col;
    logic                          o_none_found;

    grid_local_maximum_finder #(
        .MAX_COLUMNS(LINE_DEPTH),
        .SAMPLE_BITS(SAMPLE_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_sample(i_sample),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_peak_value(o_peak_value),
        .o_peak_row(o_peak_row),
        .o_peak_col(o_peak_col),
        .o_none_found(o_none_found)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // grid model state
    logic signed [SAMPLE_W-1:0] line_rows [2][LINE_DEPTH];
    logic                       upper_sel;
    int unsigned                grid_row;
    int unsigned                grid_col;
    logic                       grid_has_peak;
    logic [ROW_BITS-1:0]        row_count_reg;
    logic [COL_BITS-1:0]        column_count_reg;

    t_peak_report peak_reports_due [$];

    int fail_count     = 0;
    int cycle_count    = 0;
    int samples_sent   = 0;
    int random_sent    = 0;
    int reg_writes     = 0;
    int peaks_checked  = 0;
    int nones_checked  = 0;
    int send_idle_pct  = 32;
    int recv_stall_pct = 49;
    bit in_random      = 1'b0;

    function automatic void restart_grid_model();
        upper_sel     = 1'b0;
        grid_row      = 0;
        grid_col      = 0;
        grid_has_peak = 1'b0;
    endfunction

    function automatic void apply_register_write(logic [CFG_INDEX_BITS-1:0] idx,
                                                 logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_ROW_COUNT: begin
                row_count_reg = data[ROW_BITS-1:0];
                restart_grid_model();
            end
            CFG_COLUMN_COUNT: begin
                column_count_reg = data[COL_BITS-1:0];
                restart_grid_model();
            end
            default: ;
        endcase
    endfunction

    function automatic bit predict_grid_step(logic signed [SAMPLE_W-1:0] s,
                                             output t_peak_report rep);
        int unsigned                rows;
        int unsigned                cols;
        logic signed [SAMPLE_W-1:0] above;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] center;
        logic signed [SAMPLE_W-1:0] right;
        bit                         found;
        found = 1'b0;
        rep   = NO_REPORT;
        rows  = (row_count_reg == 0) ? 1 : row_count_reg;
        cols  = (column_count_reg == 0) ? 1 : column_count_reg;
        if (cols > LINE_DEPTH)
            cols = LINE_DEPTH;
        if (grid_row >= 2 && grid_col >= 1 && grid_col + 1 < cols) begin
            above  = line_rows[upper_sel][grid_col];
            left   = line_rows[!upper_sel][grid_col - 1];
            center = line_rows[!upper_sel][grid_col];
            right  = line_rows[!upper_sel][grid_col + 1];
            if (center > above && center > s && center > left && center > right) begin
                rep           = '{center, ROW_BITS'(grid_row), COL_BITS'(grid_col + 1), 1'b0};
                grid_has_peak = 1'b1;
                found         = 1'b1;
            end
        end
        line_rows[upper_sel][grid_col] = s;
        if (grid_col + 1 >= cols) begin
            if (grid_row + 1 >= rows) begin
                if (!grid_has_peak) begin
                    rep   = '{'0, ROW_BITS'(rows), COL_BITS'(cols), 1'b1};
                    found = 1'b1;
                end
                restart_grid_model();
            end else begin
                grid_col  = 0;
                grid_row  = grid_row + 1;
                upper_sel = !upper_sel;
            end
        end else begin
            grid_col = grid_col + 1;
        end
        return found;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return SAMPLE_W'($urandom);
            5, 6, 7:       return SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
            8:             return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default:       return $urandom_range(0, 1) ?
                                  SAMPLE_W'(16'h7FFF - $urandom_range(0, 3)) :
                                  SAMPLE_W'(16'h8000 + $urandom_range(0, 3));
        endcase
    endfunction

    // one sample transfer, with random idle cycles ahead of it
    task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
        if (in_random && random_sent >= 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end else if (in_random && random_sent >= RANDOM_ITEMS / 3) begin
            send_idle_pct  = 49;
            recv_stall_pct = 32;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do
            @(posedge i_clk);
        while (o_in_stall);
        samples_sent++;
        if (in_random)
            random_sent++;
    endtask

    task automatic feed_sample(logic signed [SAMPLE_W-1:0] s);
        t_peak_report rep;
        send_sample(s);
        if (predict_grid_step(s, rep))
            peak_reports_due.push_back(rep);
    endtask

    // counts only change with the stream drained and the block settled
    task automatic write_register(logic [CFG_INDEX_BITS-1:0] idx,
                                  logic [CFG_DATA_BITS-1:0] data);
        i_in_valid <= 1'b0;
        while (peak_reports_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        apply_register_write(idx, data);
        reg_writes++;
    endtask

    task automatic run_grid_phase(logic [CFG_DATA_BITS-1:0] rows_data,
                                  logic [CFG_DATA_BITS-1:0] cols_data, int count);
        write_register(CFG_ROW_COUNT, rows_data);
        write_register(CFG_COLUMN_COUNT, cols_data);
        repeat (count) feed_sample(draw_sample());
    endtask

    always @(posedge i_clk) begin : watch_results
        t_peak_report due;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (peak_reports_due.size() == 0) begin
                $error("unexpected result transfer: value %0d row %0d col %0d none %0b",
                       o_peak_value, o_peak_row, o_peak_col, o_none_found);
                fail_count++;
            end else begin
                due = peak_reports_due.pop_front();
                if (o_peak_value !== due.value) begin
                    $error("peak_value expected %0d got %0d", due.value, o_peak_value);
                    fail_count++;
                end
                if (o_peak_row !== due.row) begin
                    $error("peak_row expected %0d got %0d", due.row, o_peak_row);
                    fail_count++;
                end
                if (o_peak_col !== due.col) begin
                    $error("peak_col expected %0d got %0d", due.col, o_peak_col);
                    fail_count++;
                end
                if (o_none_found !== due.none) begin
                    $error("none_found expected %0b got %0b", due.none, o_none_found);
                    fail_count++;
                end
                if (due.none)
                    nones_checked++;
                else
                    peaks_checked++;
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, peak_reports_due.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        t_peak_report             rep;
        bit                       found;
        int                       rows;
        int                       cols;
        logic [CFG_DATA_BITS-1:0] rows_data;
        row_count_reg    = ROWS_AT_RESET;
        column_count_reg = COLS_AT_RESET;
        restart_grid_model();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_PLAN[k]) begin
            if (DIRECTED_PLAN[k].kind == STEP_WRITE) begin
                write_register(DIRECTED_PLAN[k].reg_index,
                               DIRECTED_PLAN[k].value[CFG_DATA_BITS-1:0]);
            end else begin
                send_sample(DIRECTED_PLAN[k].value);
                found = predict_grid_step(DIRECTED_PLAN[k].value, rep);
                if (DIRECTED_PLAN[k].typed)
                    peak_reports_due.push_back(DIRECTED_PLAN[k].report);
                else if (found)
                    peak_reports_due.push_back(rep);
            end
        end

        in_random = 1'b1;
        // widest line (saturated count) and tallest grid, cut short by a restart
        run_grid_phase(12'd3, 12'hFFF, 3 * LINE_DEPTH);
        run_grid_phase(12'd4095, 12'd3, 60);
        run_grid_phase(12'd4095, 12'd128, 300);

        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: begin
                    rows = $urandom_range(0, 2);
                    cols = $urandom_range(0, 4);
                    run_grid_phase(CFG_DATA_BITS'(rows), CFG_DATA_BITS'(cols),
                                   (rows == 0 ? 1 : rows) * (cols == 0 ? 1 : cols) *
                                   $urandom_range(1, 3));
                end
                1: begin
                    write_register($urandom_range(0, 1) ? CFG_SPARE_LOW : CFG_SPARE_HIGH,
                                   CFG_DATA_BITS'($urandom));
                    repeat ($urandom_range(1, 20)) feed_sample(draw_sample());
                end
                2: begin
                    rows = $urandom_range(3, 6);
                    cols = $urandom_range(3, 10);
                    run_grid_phase(CFG_DATA_BITS'(rows), CFG_DATA_BITS'(cols),
                                   $urandom_range(1, rows * cols - 1));
                end
                default: begin
                    rows      = $urandom_range(3, 8);
                    cols      = $urandom_range(3, 12);
                    rows_data = CFG_DATA_BITS'(rows);
                    run_grid_phase(rows_data, {4'($urandom), 8'(cols)},
                                   rows * cols * $urandom_range(1, 3));
                end
            endcase
        end

        i_in_valid <= 1'b0;
        while (peak_reports_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d sample transfers and %0d register writes",
                 samples_sent, reg_writes);
        $display("checked %0d peak and %0d no-peak results", peaks_checked, nones_checked);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
rtl/core/glmf_pkg.sv
rtl/core/glmf_cell.sv
rtl/core/glmf_line.sv
rtl/core/grid_local_maximum_finder.sv
bench/grid_local_maximum_finder_tb.sv
